FILE: src/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
package ffsa_pkg;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // offset and length width in the segment table
   localparam int OFFSET_BITS = 24;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_FIT_RD,
      S_FIT_CHK,
      S_CO_RDI,
      S_CO_WAITI,
      S_CO_RDJ,
      S_CO_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_APPLY,
      S_SUM_RD,
      S_SUM_ACC,
      S_DONE
   } state_type;

endpackage

FILE: src/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffsa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: src/first_fit_segment_allocator.sv
// First-fit segment allocator: top level with sequencer, table RAM and result register.
// Allocate walks the table to the first entry that fits; a miss adds a coalescing pass plus shifts.
// Every step goes through the single table read port walked by the sequencer.
// One word in flight; req_tready is low while a word is at work, its result waits or csr_valid.
// Reset (synchronous) loads one segment {0, 65536}; a heap_size write loads one segment {0, heap_size}.
module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS  = 64,
   parameter int MIN_REMAINDER = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] action, [24:1] request_size, [48:25] free_offset, [55:49] zero
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [25:2] block_offset, [49:26] free_bytes, [73:50] largest_free,
   // [80:74] segment_count, [87:81] zero
   output logic [87:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_data
);
   import ffsa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int UW = $clog2(MAX_SEGMENTS + 1);
   localparam int OW = OFFSET_BITS;
   localparam int EW = 2 * OW;
   localparam logic [OW:0] OMAX = {1'b0, {OW{1'b1}}};

   state_type state_ff, state_in;
   logic [UW-1:0] used_ff, used_in, i_ff, i_in, j_ff, j_in;
   logic          act_ff, act_in, retry_ff, retry_in;
   logic [23:0]   size_ff, size_in, fofs_ff, fofs_in;
   logic [OW-1:0] si_ff, si_in, li_ff, li_in;
   logic [1:0]    stat_ff, stat_in;
   logic [23:0]   blk_ff, blk_in;
   logic [24:0]   tot_ff, tot_in;
   logic [OW-1:0] big_ff, big_in;
   logic          ov_ff, ov_in;
   logic [87:0]   out_ff, out_in;
   logic          ovld_ff, ovld_in;
   logic [UW-1:0] rem_ff, rem_in;

   logic          we;
   logic [AW-1:0] wa, ra;
   logic [EW-1:0] wd, rd;
   logic [OW-1:0] rs, rl;

   ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
   );

   assign rs = rd[EW-1:OW];
   assign rl = rd[OW-1:0];

   assign req_tready = (state_ff == S_IDLE) && !ovld_ff && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE) && !ovld_ff;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ovld_ff  <= 1'b0;
         used_ff  <= UW'(1);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         used_ff  <= used_in;
         ov_ff    <= ov_in;
      end
      i_ff <= i_in; j_ff <= j_in; act_ff <= act_in; retry_ff <= retry_in;
      size_ff <= size_in; fofs_ff <= fofs_in; si_ff <= si_in; li_ff <= li_in;
      stat_ff <= stat_in; blk_ff <= blk_in;
      tot_ff <= tot_in; big_ff <= big_in; out_ff <= out_in;
      rem_ff <= rem_in;
   end

   logic [OW+1:0] need;
   logic [OW:0]   sum;
   logic [OW-1:0] cut;

   always_comb begin
      state_in = state_ff; used_in = used_ff; i_in = i_ff; j_in = j_ff;
      act_in = act_ff; retry_in = retry_ff; size_in = size_ff; fofs_in = fofs_ff;
      si_in = si_ff; li_in = li_ff;
      stat_in = stat_ff; blk_in = blk_ff; tot_in = tot_ff; big_in = big_ff;
      ov_in = ov_ff; out_in = out_ff; ovld_in = ovld_ff; rem_in = rem_ff;
      we = 1'b0; wa = '0; wd = '0; ra = i_ff[AW-1:0];
      need = {2'b0, OW'(size_ff)} + (OW+2)'(MIN_REMAINDER);
      sum  = {1'b0, rl} + {1'b0, li_ff};
      cut  = li_ff - OW'(size_ff);
      if (ovld_ff && rsp_tready) ovld_in = 1'b0;
      case (state_ff)
         S_INIT: begin
            we = 1'b1; wd = {OW'(0), OW'(24'd65536)};
            used_in = UW'(1); state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!ovld_ff && csr_valid) begin
               we = 1'b1; wd = {OW'(0), OW'(csr_data)}; used_in = UW'(1);
            end else if (!ovld_ff && req_tvalid) begin
               act_in = req_tdata[0]; size_in = req_tdata[24:1];
               fofs_in = req_tdata[48:25];
               stat_in = ST_OK; blk_in = '0; i_in = '0; retry_in = 1'b0;
               if (req_tdata[0] == ACT_FREE) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_FIT_RD;
               end
            end
         end
         S_FIT_RD: begin
            if (i_ff >= used_ff) begin
               if (retry_ff) begin
                  stat_in = ST_NOFIT; state_in = S_APPLY;
               end else begin
                  retry_in = 1'b1; i_in = '0; state_in = S_CO_RDI;
               end
            end else begin
               ra = i_ff[AW-1:0]; state_in = S_FIT_CHK;
            end
         end
         S_FIT_CHK: begin
            if ({{(OW+2-OW){1'b0}}, rl} == {2'b0, OW'(size_ff)} ||
                {2'b0, rl} >= need) begin
               si_in = rs; li_in = rl; state_in = S_APPLY;
            end else begin
               i_in = i_ff + UW'(1); state_in = S_FIT_RD;
            end
         end
         // coalescing: entry i against every other j
         S_CO_RDI: begin
            if (i_ff >= used_ff) begin
               i_in = '0; state_in = S_FIT_RD;
            end else begin
               ra = i_ff[AW-1:0]; state_in = S_CO_WAITI;
            end
         end
         S_CO_WAITI: begin
            si_in = rs; li_in = rl; j_in = '0; state_in = S_CO_RDJ;
         end
         S_CO_RDJ: begin
            if (j_ff == i_ff) j_in = j_ff + UW'(1);
            if (j_ff >= used_ff || (j_ff == i_ff && j_ff + UW'(1) >= used_ff)) begin
               i_in = i_ff + UW'(1); state_in = S_CO_RDI;
            end else if (j_ff != i_ff) begin
               ra = j_ff[AW-1:0]; state_in = S_CO_CHK;
            end
         end
         S_CO_CHK: begin
            if ({1'b0, rs} + {1'b0, rl} == {1'b0, si_ff}) begin
               we = 1'b1; wa = j_ff[AW-1:0];
               wd = {rs, (sum > OMAX) ? {OW{1'b1}} : sum[OW-1:0]};
               rem_in = i_ff; state_in = S_SHIFT_RD;
            end else begin
               j_in = j_ff + UW'(1); state_in = S_CO_RDJ;
            end
         end
         // remove entry rem: shift the tail up one place
         S_SHIFT_RD: begin
            if (rem_ff + UW'(1) >= used_ff) begin
               used_in = used_ff - UW'(1);
               state_in = S_CO_RDI;
               if (ov_ff) begin
                  state_in = S_SUM_RD; i_in = '0; tot_in = '0; big_in = '0;
               end
            end else begin
               ra = AW'(rem_ff + UW'(1)); state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            we = 1'b1; wa = rem_ff[AW-1:0]; wd = rd;
            rem_in = rem_ff + UW'(1); state_in = S_SHIFT_RD;
         end
         S_APPLY: begin
            ov_in = 1'b1; i_in = '0; tot_in = '0; big_in = '0; state_in = S_SUM_RD;
            if (act_ff == ACT_FREE) begin
               if (used_ff >= UW'(MAX_SEGMENTS)) begin
                  stat_in = ST_FULL;
               end else begin
                  we = 1'b1; wa = used_ff[AW-1:0];
                  wd = {OW'(fofs_ff), OW'(size_ff)}; used_in = used_ff + UW'(1);
               end
            end else if (stat_ff == ST_OK) begin
               if (li_ff == OW'(size_ff)) begin
                  blk_in = 24'(si_ff); rem_in = i_ff; state_in = S_SHIFT_RD;
               end else begin
                  we = 1'b1; wa = i_ff[AW-1:0]; wd = {si_ff, cut};
                  blk_in = 24'(si_ff + cut);
               end
            end
         end
         S_SUM_RD: begin
            if (i_ff >= used_ff) begin
               state_in = S_DONE;
            end else begin
               ra = i_ff[AW-1:0]; state_in = S_SUM_ACC;
            end
         end
         S_SUM_ACC: begin
            tot_in = tot_ff + 25'(rl);
            if (tot_in[24] || tot_ff[24]) tot_in = {1'b1, 24'hFFFFFF};
            if (rl > big_ff) big_in = rl;
            i_in = i_ff + UW'(1); state_in = S_SUM_RD;
         end
         S_DONE: begin
            out_in = {7'd0, 7'(used_ff), 24'(big_ff),
                      tot_ff[24] ? 24'hFFFFFF : tot_ff[23:0], blk_ff, stat_ff};
            ovld_in = 1'b1; ov_in = 1'b0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAX_SEGMENTS)) else $error("segment count overflow");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while result held");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
`endif
endmodule

FILE: tb/first_fit_segment_allocator_tb.sv
// Self-checking testbench for the first-fit segment allocator: directed table, then random phases.
module first_fit_segment_allocator_tb;
   import ffsa_pkg::*;

   localparam int NSEG      = 64;
   localparam int WD_LIMIT  = 100000;
   localparam int HOLD_LEN  = 400;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] blk;
      logic [23:0] fbytes;
      logic [23:0] largest;
      logic [6:0]  cnt;
   } alloc_res_type;

   typedef struct {
      logic          act;
      logic [23:0]   size;
      logic [23:0]   ofs;
      bit            typed;
      alloc_res_type res;
   } row_type;

   typedef struct {
      logic [23:0] ofs;
      logic [23:0] size;
   } live_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [23:0] csr_data = '0;

   // own copy of the free table
   logic [23:0] seg_start [NSEG];
   logic [23:0] seg_len   [NSEG];
   int          seg_used;

   alloc_res_type pending[$];
   live_type      live_blocks[$];
   int          errors = 0;
   int          rsp_seen = 0;
   bit          quiet = 0;
   bit          held = 0;
   int          idle_cycles = 0;

   first_fit_segment_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic void table_load(logic [23:0] hs);
      seg_start[0] = '0;
      seg_len[0] = hs;
      seg_used = 1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int k = idx; k + 1 < seg_used; k++) begin
         seg_start[k] = seg_start[k+1];
         seg_len[k] = seg_len[k+1];
      end
      seg_used--;
   endfunction

   function automatic int first_fit(logic [23:0] size);
      int hit;
      hit = -1;
      for (int k = 0; k < seg_used && hit < 0; k++)
         if (seg_len[k] == size || {1'b0, seg_len[k]} >= {1'b0, size} + 25'd12) hit = k;
      return hit;
   endfunction

   function automatic void merge_pass();
      int  i;
      bit  merged;
      logic [24:0] sum;
      i = 0;
      while (i < seg_used) begin
         merged = 0;
         for (int j = 0; j < seg_used && !merged; j++) begin
            if (j != i && {1'b0, seg_start[j]} + {1'b0, seg_len[j]} == {1'b0, seg_start[i]}) begin
               sum = {1'b0, seg_len[j]} + {1'b0, seg_len[i]};
               seg_len[j] = sum[24] ? 24'hFFFFFF : sum[23:0];
               drop_entry(i);
               merged = 1;
            end
         end
         if (!merged) i++;
      end
   endfunction

   function automatic alloc_res_type heap_step(logic act, logic [23:0] size, logic [23:0] ofs);
      alloc_res_type r;
      int idx;
      logic [31:0] total;
      r = '0;
      if (act == ACT_ALLOC) begin
         idx = first_fit(size);
         if (idx < 0) begin
            merge_pass();
            idx = first_fit(size);
         end
         if (idx < 0) r.status = ST_NOFIT;
         else if (seg_len[idx] == size) begin
            r.blk = seg_start[idx];
            drop_entry(idx);
         end else begin
            seg_len[idx] = seg_len[idx] - size;
            r.blk = seg_start[idx] + seg_len[idx];
         end
      end else if (seg_used >= NSEG) begin
         r.status = ST_FULL;
      end else begin
         seg_start[seg_used] = ofs;
         seg_len[seg_used] = size;
         seg_used++;
      end
      total = 0;
      for (int k = 0; k < seg_used; k++) begin
         total += 32'(seg_len[k]);
         if (seg_len[k] > r.largest) r.largest = seg_len[k];
      end
      r.fbytes = (total > 32'hFFFFFF) ? 24'hFFFFFF : total[23:0];
      r.cnt = seg_used[6:0];
      return r;
   endfunction

   task automatic send_word(logic act, logic [23:0] size, logic [23:0] ofs,
                            bit typed = 0, alloc_res_type want = '0);
      alloc_res_type r;
      req_tdata <= {7'd0, ofs, size, act};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      r = heap_step(act, size, ofs);
      pending.push_back(typed ? want : r);
      if (act == ACT_ALLOC && r.status == ST_OK && size != 0) live_blocks.push_back('{r.blk, size});
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic write_heap(logic [23:0] hs);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_data <= hs;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      table_load(hs);
      live_blocks.delete();
   endtask

   task automatic random_phase(int n, int free_pct);
      int r, pick;
      logic [23:0] sz;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r >= free_pct) begin
            sz = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 600));
            send_word(ACT_ALLOC, sz, 24'($urandom));
         end else if (live_blocks.size() != 0 && r < free_pct * 3 / 4) begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            send_word(ACT_FREE, live_blocks[pick].size, live_blocks[pick].ofs);
            live_blocks.delete(pick);
         end else begin
            sz = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
            send_word(ACT_FREE, sz, 24'($urandom));
         end
      end
   endtask

   // after reset the heap is one segment of 65536 bytes
   row_type rows[] = '{
      '{ACT_ALLOC, 24'd16,     24'd0,   1, '{ST_OK, 24'd65520, 24'd65520, 24'd65520, 7'd1}},
      '{ACT_ALLOC, 24'd65520,  24'd0,   1, '{ST_OK, 24'd0, 24'd0, 24'd0, 7'd0}},
      '{ACT_ALLOC, 24'd1,      24'd0,   1, '{ST_NOFIT, 24'd0, 24'd0, 24'd0, 7'd0}},
      '{ACT_FREE,  24'd100,    24'd0,   0, '0},
      '{ACT_FREE,  24'd16,     24'd100, 0, '0},
      '{ACT_ALLOC, 24'd0,      24'd0,   0, '0},
      '{ACT_ALLOC, 24'd95,     24'd0,   0, '0},
      '{ACT_FREE,  24'd0,      24'd500, 0, '0},
      '{ACT_ALLOC, 24'd0,      24'd0,   0, '0},
      '{ACT_FREE,  24'hFFFFFF, 24'hFFFFFF, 0, '0},
      '{ACT_FREE,  24'd10,     24'hFFFFF8, 0, '0},
      '{ACT_ALLOC, 24'hFFFFF0, 24'hFFFFFF, 0, '0},
      '{ACT_ALLOC, 24'hFFFFFF, 24'd0,   0, '0},
      '{ACT_FREE,  24'h800000, 24'h7FFFFF, 0, '0},
      '{ACT_FREE,  24'h800000, 24'hFFFFFF, 0, '0},
      '{ACT_ALLOC, 24'd21,     24'd0,   0, '0},
      '{ACT_ALLOC, 24'd10,     24'd0,   0, '0},
      '{ACT_ALLOC, 24'hAAAAAA, 24'h555555, 0, '0},
      '{ACT_FREE,  24'h555555, 24'hAAAAAA, 0, '0}
   };

   initial begin
      table_load(24'd65536);
      repeat (2) @(posedge clock);
      reset <= 0;
      foreach (rows[i]) send_word(rows[i].act, rows[i].size, rows[i].ofs, rows[i].typed, rows[i].res);
      random_phase(100, 50);
      write_heap(24'd0);
      random_phase(40, 40);
      write_heap(24'hFFFFFF);
      random_phase(100, 45);
      write_heap(24'd4096);
      random_phase(120, 85);   // free-heavy: fills the table
      write_heap(24'($urandom_range(1, 24'hFFFFFF)));
      quiet = 1;
      random_phase(120, 50);
      req_tvalid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("[first_fit_segment_allocator] OK");
      else $display("[first_fit_segment_allocator] ERROR");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off to back the block up
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!held && rsp_seen >= 30) begin
            held = 1;
            stall = HOLD_LEN;
         end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0)
            stall = $urandom_range(1, 16);
         if (quiet && held && stall > 0 && stall <= 16) stall = 0;
         rsp_tready <= (stall == 0);
         if (stall > 0) stall--;
      end
   end

   task automatic cmp_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      alloc_res_type want;
      if (rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (pending.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending.pop_front();
            cmp_field("status", 24'(want.status), 24'(rsp_tdata[1:0]));
            cmp_field("block_offset", want.blk, rsp_tdata[25:2]);
            cmp_field("free_bytes", want.fbytes, rsp_tdata[49:26]);
            cmp_field("largest_free", want.largest, rsp_tdata[73:50]);
            cmp_field("segment_count", 24'(want.cnt), 24'(rsp_tdata[80:74]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WD_LIMIT) begin
         $display("[first_fit_segment_allocator] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule

FILE: sim.f
src/ffsa_pkg.sv
src/ffsa_ram.sv
src/first_fit_segment_allocator.sv
tb/first_fit_segment_allocator_tb.sv
